>>> rtl/i2a_pkg.sv
// Shared constants, types and functions for the integer to ASCII formatter.
package i2a_pkg;

    localparam int VALUE_BITS = 32;

    // Decimal digits of 2^VALUE_BITS - 1 (log10(2) ~ 1233/4096).
    localparam int DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int CNT_W      = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    localparam int TDATA_W    = ((VALUE_BITS + 7) / 8) * 8;

    // Shift-and-add-3 conversion split over a fixed number of stages.
    localparam int DD_STAGES  = 4;
    localparam int DD_STEPS   = HEX_DIGITS;            // steps per stage
    localparam int DD_BITS    = 4 * HEX_DIGITS;        // DD_STAGES * DD_STEPS >= VALUE_BITS
    localparam int BCD_W      = 4 * DEC_DIGITS;

    localparam logic [7:0] ASCII_ZERO      = 8'd48;
    localparam logic [7:0] ASCII_ALPHA_OFS = 8'd87;
    localparam logic [7:0] ASCII_MINUS     = 8'd45;

    typedef struct packed {
        logic               hex;
        logic               neg;
        logic [DD_BITS-1:0] bin;
        logic [BCD_W-1:0]   bcd;
    } work_t;

    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    // One stage worth of double-dabble steps; hex items pass untouched.
    // Magnitude is zero-extended at the top, so extra steps only shift zeros.
    function automatic work_t dabble(input work_t w);
        work_t r;
        int    s;
        int    d;
        r = w;
        if (!w.hex) begin
            for (s = 0; s < DD_STEPS; s++) begin
                for (d = 0; d < DEC_DIGITS; d++) begin
                    if (r.bcd[4*d +: 4] >= 4'd5) begin
                        r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
                    end
                end
                {r.bcd, r.bin} = {r.bcd[BCD_W-2:0], r.bin, 1'b0};
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] to_ascii(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = ASCII_ZERO + {4'd0, nib};
        end else begin
            c = ASCII_ALPHA_OFS + {4'd0, nib};
        end
        return c;
    endfunction

endpackage

>>> rtl/i2a_dabble_stage.sv
// One register stage of the pipelined binary to BCD converter.
module i2a_dabble_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  i2a_pkg::work_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output i2a_pkg::work_t  out_data
);

    logic           valid_reg;
    logic           valid_next;
    i2a_pkg::work_t data_reg;
    i2a_pkg::work_t data_next;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign data_next  = i2a_pkg::dabble(in_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/integer_to_ascii_formatter.sv
// Top level: formats a value as signed decimal or lowercase hex ASCII characters.
//
//  port group   dir  tdata                       tuser        tlast
//  s_ (value)   in   [31:0] value                [0] mode     -
//  m_ (chars)   out  [7:0]  ascii_char           -            last
//
// An input transaction reaches its first character through one input stage, four
// double-dabble stages of eight shift steps each, one digit-count stage and the output
// register. The output register emits one character per cycle while m_tready is high, so
// an item takes 1 to 11 characters (sign plus digits). Items enter the pipeline
// every cycle until it fills behind the output. Reset clears all valid bits.
// Backpressure on m_tready stalls every stage in place; nothing is dropped or repeated.
module integer_to_ascii_formatter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [i2a_pkg::TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic [0:0]                  s_tuser,   // [0] mode: 0 decimal, 1 hex
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [7:0] ascii_char
    output logic                        m_tlast
);

    localparam int VB  = i2a_pkg::VALUE_BITS;
    localparam int NS  = i2a_pkg::DD_STAGES;
    localparam int NDG = i2a_pkg::NUM_DIGITS;

    // ---------------- input stage: sign and magnitude ----------------
    logic                  s0_valid_reg;
    i2a_pkg::work_t        s0_data_reg;
    i2a_pkg::work_t        s0_data_next;
    logic                  s0_ready;
    logic [VB-1:0]         in_val;
    logic                  in_neg;
    logic [VB-1:0]         in_mag;

    logic [NS:0]           st_valid;
    logic [NS:0]           st_ready;
    i2a_pkg::work_t [NS:0] st_data;

    assign in_val = s_tdata[VB-1:0];
    assign in_neg = !s_tuser[0] && in_val[VB-1];
    assign in_mag = in_neg ? (~in_val + {{(VB-1){1'b0}}, 1'b1}) : in_val;

    always_comb begin
        s0_data_next     = '0;
        s0_data_next.hex = s_tuser[0];
        s0_data_next.neg = in_neg;
        s0_data_next.bin = i2a_pkg::DD_BITS'(in_mag);
    end

    assign s0_ready = !s0_valid_reg || st_ready[0];
    assign s_tready = s0_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (s0_ready) begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s0_ready) begin
            s0_data_reg <= s0_data_next;
        end
    end

    // ---------------- double-dabble stages ----------------
    assign st_valid[0] = s0_valid_reg;
    assign st_data[0]  = s0_data_reg;

    for (genvar g = 0; g < NS; g++) begin : g_dd
        i2a_dabble_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[g]),
            .in_ready  (st_ready[g]),
            .in_data   (st_data[g]),
            .out_valid (st_valid[g+1]),
            .out_ready (st_ready[g+1]),
            .out_data  (st_data[g+1])
        );
    end

    // ---------------- digit count stage ----------------
    logic                       s5_valid_reg;
    logic                       s5_neg_reg;
    i2a_pkg::digits_t           s5_dig_reg;
    logic [i2a_pkg::CNT_W-1:0]  s5_nd_reg;
    i2a_pkg::digits_t           dig_next;
    logic [i2a_pkg::CNT_W-1:0]  nd_next;
    logic                       s5_ready;
    logic                       ser_ready;

    always_comb begin
        dig_next = '0;
        if (st_data[NS].hex) begin
            for (int i = 0; i < i2a_pkg::HEX_DIGITS; i++) begin
                dig_next[i] = st_data[NS].bin[4*i +: 4];
            end
        end else begin
            for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
                dig_next[i] = st_data[NS].bcd[4*i +: 4];
            end
        end
    end

    // Highest nonzero digit sets the count; zero still gives one digit.
    always_comb begin
        nd_next = i2a_pkg::CNT_W'(1);
        for (int i = 1; i < NDG; i++) begin
            if (dig_next[i] != 4'd0) begin
                nd_next = i2a_pkg::CNT_W'(i + 1);
            end
        end
    end

    assign s5_ready       = !s5_valid_reg || ser_ready;
    assign st_ready[NS]   = s5_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (s5_ready) begin
            s5_valid_reg <= st_valid[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (s5_ready) begin
            s5_neg_reg <= st_data[NS].neg;
            s5_dig_reg <= dig_next;
            s5_nd_reg  <= nd_next;
        end
    end

    // ---------------- character serializer / output register ----------------
    logic                       m_valid_reg;
    logic                       m_valid_next;
    logic [7:0]                 m_data_reg;
    logic [7:0]                 m_data_next;
    logic                       m_last_reg;
    logic                       m_last_next;
    logic [i2a_pkg::CNT_W-1:0]  cnt_reg;     // digits still to emit after current char
    logic [i2a_pkg::CNT_W-1:0]  cnt_next;
    i2a_pkg::digits_t           dig_reg;
    logic                       ser_load;
    logic                       ser_step;
    logic [i2a_pkg::CNT_W-1:0]  nd_m1;
    logic [i2a_pkg::CNT_W-1:0]  cnt_m1;

    assign ser_ready = !m_valid_reg || (m_tready && m_last_reg);
    assign ser_load  = s5_valid_reg && ser_ready;
    assign ser_step  = m_valid_reg && m_tready && !m_last_reg;
    assign nd_m1     = s5_nd_reg - i2a_pkg::CNT_W'(1);
    assign cnt_m1    = cnt_reg - i2a_pkg::CNT_W'(1);

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        cnt_next     = cnt_reg;
        if (ser_load) begin
            m_valid_next = 1'b1;
            if (s5_neg_reg) begin
                m_data_next = i2a_pkg::ASCII_MINUS;
                m_last_next = 1'b0;
                cnt_next    = s5_nd_reg;
            end else begin
                m_data_next = i2a_pkg::to_ascii(s5_dig_reg[nd_m1[i2a_pkg::IDX_W-1:0]]);
                m_last_next = (nd_m1 == '0);
                cnt_next    = nd_m1;
            end
        end else if (ser_step) begin
            m_data_next = i2a_pkg::to_ascii(dig_reg[cnt_m1[i2a_pkg::IDX_W-1:0]]);
            m_last_next = (cnt_m1 == '0);
            cnt_next    = cnt_m1;
        end else if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        cnt_reg    <= cnt_next;
        if (ser_load) begin
            dig_reg <= s5_dig_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
